### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define SPHDK_ASSERT_NOW(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (r) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is high.
`define SPHDK_ASSERT_NEXT(label, c, r, ante, cons, msg) \
  label: assert property (@(posedge c) disable iff (r) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sphdk_pkg.sv
// Types and constants for the SPH cubic-spline density pair kernel.
package sphdk_pkg;

  localparam int LEN_FRAC_BITS_DEF  = 24;
  localparam int MASS_FRAC_BITS_DEF = 16;

  // Datapath widths
  localparam int ROOT_W = 32;   // square roots of 64-bit values
  localparam int KW_W   = 63;   // kernel weight, Q.32, capped at 2^62
  localparam int KK_W   = 94;   // weight times normalization
  localparam int PROD_W = 126;  // weight times normalization times mass
  localparam int DEN_W  = 64;   // ball_sq times its root
  localparam int QUO_W  = 47;   // gain magnitude below the cap
  localparam int GAIN_W = 48;
  localparam int CTX_W  = 66;   // both masses, last flag, zero-ball flag

  localparam logic [30:0]       NORM_CONST = 31'd1367130551;  // 2^30 * 4/pi
  localparam logic [KW_W-1:0]   W_CAP      = {1'b1, 62'd0};
  localparam logic [KW_W-1:0]   W_ONE      = 63'h1_0000_0000;
  localparam logic [33:0]       Q_TWO      = 34'h2_0000;      // q = 2 in Q.16
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [GAIN_W-1:0] GAIN_CAP   = 48'h8000_0000_0000;

  typedef struct packed {
    logic [31:0] dist_sq;
    logic [31:0] ball_sq;
    logic [31:0] center_mass;
    logic [31:0] neighbor_mass;
    logic        last_pair;
  } pair_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] center_gain;
    logic signed [GAIN_W-1:0] neighbor_gain;
    logic                     kernel_negative;
    logic                     ball_zero;
    logic                     last_out;
  } result_t;

endpackage

### rtl/sphdk_udiv.sv
// Pipelined restoring divider, STEP quotient bits per stage, with a sideband line.
module sphdk_udiv #(
  parameter int DEN_W  = 32,
  parameter int Q_W    = 64,
  parameter int STEP   = 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              en,
  input  logic [DEN_W-1:0]  rem_in,   // upper numerator part, below den
  input  logic [Q_W-1:0]    num_lo,   // lower numerator bits, msb first
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] side_out
);

  localparam int Stages = Q_W / STEP;

  logic [DEN_W-1:0]  rem_q  [Stages];
  logic [Q_W-1:0]    lo_q   [Stages];
  logic [Q_W-1:0]    quo_q  [Stages];
  logic [DEN_W-1:0]  den_q  [Stages];
  logic [SIDE_W-1:0] side_q [Stages];

  for (genvar g = 0; g < Stages; g++) begin : g_stage
    logic [DEN_W-1:0]  rem_src;
    logic [Q_W-1:0]    lo_src;
    logic [Q_W-1:0]    quo_src;
    logic [DEN_W-1:0]  den_src;
    logic [SIDE_W-1:0] side_src;
    logic [DEN_W-1:0]  rem_next;
    logic [Q_W-1:0]    lo_next;
    logic [Q_W-1:0]    quo_next;

    if (g == 0) begin : g_head
      assign rem_src  = rem_in;
      assign lo_src   = num_lo;
      assign quo_src  = '0;
      assign den_src  = den;
      assign side_src = side_in;
    end else begin : g_body
      assign rem_src  = rem_q[g-1];
      assign lo_src   = lo_q[g-1];
      assign quo_src  = quo_q[g-1];
      assign den_src  = den_q[g-1];
      assign side_src = side_q[g-1];
    end

    // Shift in STEP numerator bits one by one, subtract when each fits
    always_comb begin
      logic [DEN_W:0] trial;
      rem_next = rem_src;
      lo_next  = lo_src;
      quo_next = quo_src;
      for (int k = 0; k < STEP; k++) begin
        trial   = {rem_next, lo_next[Q_W-1]};
        lo_next = lo_next << 1;
        if (trial >= {1'b0, den_src}) begin
          trial    = trial - {1'b0, den_src};
          quo_next = {quo_next[Q_W-2:0], 1'b1};
        end else begin
          quo_next = {quo_next[Q_W-2:0], 1'b0};
        end
        rem_next = trial[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g]  <= rem_next;
        lo_q[g]   <= lo_next;
        quo_q[g]  <= quo_next;
        den_q[g]  <= den_src;
        side_q[g] <= side_src;
      end
    end
  end

  assign quo      = quo_q[Stages-1];
  assign side_out = side_q[Stages-1];

endmodule

### rtl/sphdk_isqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
module sphdk_isqrt #(
  parameter int ROOT_W = 32,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   radicand,
  input  logic [SIDE_W-1:0]     side_in,
  output logic [ROOT_W-1:0]     root,
  output logic [ROOT_W:0]       rem,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int VW   = 2 * ROOT_W;
  localparam int RemW = ROOT_W + 2;

  logic [VW-1:0]     v_q    [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [RemW-1:0]   rem_q  [ROOT_W];
  logic [SIDE_W-1:0] side_q [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    logic [VW-1:0]     v_src;
    logic [ROOT_W-1:0] root_src;
    logic [RemW-1:0]   rem_src;
    logic [SIDE_W-1:0] side_src;
    logic [RemW-1:0]   cur;
    logic [RemW-1:0]   trial;
    logic [RemW-1:0]   rem_next;
    logic [ROOT_W-1:0] root_next;

    if (g == 0) begin : g_head
      assign v_src    = radicand;
      assign root_src = '0;
      assign rem_src  = '0;
      assign side_src = side_in;
    end else begin : g_body
      assign v_src    = v_q[g-1];
      assign root_src = root_q[g-1];
      assign rem_src  = rem_q[g-1];
      assign side_src = side_q[g-1];
    end

    // Bring down two radicand bits, try root*4+1
    assign cur   = {rem_src[ROOT_W-1:0], v_src[VW-1:VW-2]};
    assign trial = {root_src, 2'b01};

    always_comb begin
      if (cur >= trial) begin
        rem_next  = cur - trial;
        root_next = {root_src[ROOT_W-2:0], 1'b1};
      end else begin
        rem_next  = cur;
        root_next = {root_src[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[g]    <= v_src << 2;
        root_q[g] <= root_next;
        rem_q[g]  <= rem_next;
        side_q[g] <= side_src;
      end
    end
  end

  assign root     = root_q[ROOT_W-1];
  assign rem      = rem_q[ROOT_W-1][ROOT_W:0];
  assign side_out = side_q[ROOT_W-1];

endmodule

### rtl/sph_density_pair_kernel_core.sv
// Top level: SPH cubic-spline density kernel for one centre-neighbour pair.
//
//   Channel   Dir  Payload               Handshake
//   pair      in   sphdk_pkg::pair_t     pair_valid / pair_ready
//   result    out  sphdk_pkg::result_t   result_valid / result_ready
//
// One pair enters per cycle while no result waits untaken; 121 register stages
// lie between a pair and its result.
// Stages: 32-stage ratio divider (two quotient bits a stage) beside a 32-stage
// ball root, a 32-stage ratio root, 4 weight stages, 4 product stages, one
// scaling stage, a 47-stage gain divider and the output register.
// Reset clears the valid line only; data registers hold whatever they had.
// While a result waits untaken, every stage holds and pair_ready is low.
module sph_density_pair_kernel_core #(
  parameter int LEN_FRAC_BITS  = sphdk_pkg::LEN_FRAC_BITS_DEF,
  parameter int MASS_FRAC_BITS = sphdk_pkg::MASS_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pair_valid,
  output logic                pair_ready,
  input  sphdk_pkg::pair_t    pair,
  output logic                result_valid,
  input  logic                result_ready,
  output sphdk_pkg::result_t  result
);

  localparam int RootW    = sphdk_pkg::ROOT_W;
  localparam int CtxW     = sphdk_pkg::CTX_W;
  localparam int DenW     = sphdk_pkg::DEN_W;
  localparam int KwW      = sphdk_pkg::KW_W;
  localparam int KkW      = sphdk_pkg::KK_W;
  localparam int ProdW    = sphdk_pkg::PROD_W;
  localparam int QuoW     = sphdk_pkg::QUO_W;
  localparam int GainW    = sphdk_pkg::GAIN_W;
  localparam int SqrtPre  = 32 - (LEN_FRAC_BITS % 2);
  localparam int NetShift = LEN_FRAC_BITS + (LEN_FRAC_BITS + SqrtPre) / 2
                            - MASS_FRAC_BITS - 38;
  localparam int PadL     = (NetShift > 0) ? NetShift : 0;
  localparam int PadR     = (NetShift < 0) ? -NetShift : 0;
  localparam int NxW      = ProdW + PadL;
  localparam int HiW      = NxW - QuoW;
  localparam int SideBW   = DenW + 1 + 30 + CtxW;
  localparam int Lat      = 2 * RootW + 4 + 4 + 1 + QuoW + 1;

  // Valid line and global stall
  logic [Lat-1:0] vld;
  logic           adv;

  assign adv          = !vld[Lat-1] || result_ready;
  assign pair_ready   = adv;
  assign result_valid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Lat-2:0], pair_valid};
    end
  end

  // Ratio d2/b2 in Q32.32 beside the root of the ball
  logic              bz_in;
  logic [63:0]       x_ratio;
  logic [CtxW-1:0]   a_ctx;
  logic [RootW-1:0]  sb;
  logic [31:0]       b_hold;

  assign bz_in = (pair.ball_sq == '0);

  sphdk_udiv #(
    .DEN_W (32),
    .Q_W   (64),
    .STEP  (2),
    .SIDE_W(CtxW)
  ) u_ratio_div (
    .clk     (clk),
    .en      (adv),
    .rem_in  ('0),
    .num_lo  ({pair.dist_sq, 32'd0}),
    .den     (pair.ball_sq),
    .side_in ({pair.center_mass, pair.neighbor_mass, pair.last_pair, bz_in}),
    .quo     (x_ratio),
    .side_out(a_ctx)
  );

  sphdk_isqrt #(
    .ROOT_W(RootW),
    .SIDE_W(32)
  ) u_ball_root (
    .clk     (clk),
    .en      (adv),
    .radicand(64'(pair.ball_sq) << SqrtPre),
    .side_in (pair.ball_sq),
    .root    (sb),
    .rem     (),
    .side_out(b_hold)
  );

  // Root of the ratio; denominator product rides along
  logic [DenW-1:0]   den_c;
  logic [RootW-1:0]  s_root;
  logic [RootW:0]    s_rem;
  logic [SideBW-1:0] b_side;

  assign den_c = 64'(b_hold) * 64'(sb);

  sphdk_isqrt #(
    .ROOT_W(RootW),
    .SIDE_W(SideBW)
  ) u_ratio_root (
    .clk     (clk),
    .en      (adv),
    .radicand(x_ratio),
    .side_in ({den_c, (x_ratio[63:30] == '0), x_ratio[29:0], a_ctx}),
    .root    (s_root),
    .rem     (s_rem),
    .side_out(b_side)
  );

  logic [DenW-1:0] b_den;
  logic            b_inner;
  logic [29:0]     b_x30;
  logic [CtxW-1:0] b_ctx;

  assign b_den   = b_side[SideBW-1 -: DenW];
  assign b_inner = b_side[30 + CtxW];
  assign b_x30   = b_side[CtxW +: 30];
  assign b_ctx   = b_side[CtxW-1:0];

  // W1: q in Q.16 (rounded 2*sqrt), branch select
  logic [33:0] qv;
  logic [33:0] rs_full;
  logic [33:0] a_full;
  logic        neg_c;

  assign qv      = {1'b0, s_root, 1'b0} + 34'(s_rem > {1'b0, s_root});
  assign rs_full = sphdk_pkg::Q_TWO - qv;
  assign a_full  = qv - sphdk_pkg::Q_TWO;
  assign neg_c   = !b_inner && (qv > sphdk_pkg::Q_TWO);

  logic [26:0]     w1_u;
  logic [17:0]     w1_rs;
  logic            w1_inner;
  logic            w1_neg;
  logic            w1_big;
  logic [29:0]     w1_x30;
  logic [DenW-1:0] w1_den;
  logic [CtxW-1:0] w1_ctx;

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_u     <= neg_c ? a_full[26:0] : 27'(rs_full[17:0]);
      w1_rs    <= rs_full[17:0];
      w1_inner <= b_inner;
      w1_neg   <= neg_c;
      w1_big   <= (a_full[33:27] != '0);
      w1_x30   <= b_x30;
      w1_den   <= b_den;
      w1_ctx   <= b_ctx;
    end
  end

  // W2: inner product rs*4x, square of the cubic base
  logic [49:0]     w2_pin;
  logic [53:0]     w2_sq;
  logic [26:0]     w2_u;
  logic            w2_inner;
  logic            w2_neg;
  logic            w2_big;
  logic [DenW-1:0] w2_den;
  logic [CtxW-1:0] w2_ctx;

  always_ff @(posedge clk) begin
    if (adv) begin
      w2_pin   <= 50'(w1_rs) * 50'({w1_x30, 2'b00});
      w2_sq    <= 54'(w1_u) * 54'(w1_u);
      w2_u     <= w1_u;
      w2_inner <= w1_inner;
      w2_neg   <= w1_neg;
      w2_big   <= w1_big;
      w2_den   <= w1_den;
      w2_ctx   <= w1_ctx;
    end
  end

  // W3: inner weight 1 - 3*rs*r2/2^18, cube partial products
  logic [51:0]     p3;
  logic [KwW-1:0]  w3_kwin;
  logic [53:0]     w3_ph;
  logic [53:0]     w3_pl;
  logic            w3_inner;
  logic            w3_neg;
  logic            w3_big;
  logic [DenW-1:0] w3_den;
  logic [CtxW-1:0] w3_ctx;

  assign p3 = 52'(w2_pin) + 52'({w2_pin, 1'b0});

  always_ff @(posedge clk) begin
    if (adv) begin
      w3_kwin  <= sphdk_pkg::W_ONE - 63'(p3[51:18]);
      w3_ph    <= 54'(w2_sq[53:27]) * 54'(w2_u);
      w3_pl    <= 54'(w2_sq[26:0]) * 54'(w2_u);
      w3_inner <= w2_inner;
      w3_neg   <= w2_neg;
      w3_big   <= w2_big;
      w3_den   <= w2_den;
      w3_ctx   <= w2_ctx;
    end
  end

  // W4: pick the weight, cap the negative tail
  logic [80:0]     cube;
  logic [KwW-1:0]  c18;
  logic [KwW-1:0]  kw_c;
  logic [KwW-1:0]  w4_kw;
  logic            w4_neg;
  logic [DenW-1:0] w4_den;
  logic [CtxW-1:0] w4_ctx;

  assign cube = (81'(w3_ph) << 27) + 81'(w3_pl);
  assign c18  = cube[80:18];

  always_comb begin
    if (w3_inner) begin
      kw_c = w3_kwin;
    end else if (!w3_neg) begin
      kw_c = c18;
    end else if (w3_big || (c18 > sphdk_pkg::W_CAP)) begin
      kw_c = sphdk_pkg::W_CAP;
    end else begin
      kw_c = c18;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w4_kw  <= kw_c;
      w4_neg <= w3_neg;
      w4_den <= w3_den;
      w4_ctx <= w3_ctx;
    end
  end

  // M1/M2: weight times normalization constant
  logic [62:0]     m1_lo;
  logic [61:0]     m1_hi;
  logic            m1_neg;
  logic [DenW-1:0] m1_den;
  logic [CtxW-1:0] m1_ctx;
  logic [KkW-1:0]  m2_kk;
  logic            m2_neg;
  logic [DenW-1:0] m2_den;
  logic [CtxW-1:0] m2_ctx;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_lo  <= 63'(w4_kw[31:0]) * 63'(sphdk_pkg::NORM_CONST);
      m1_hi  <= 62'(w4_kw[62:32]) * 62'(sphdk_pkg::NORM_CONST);
      m1_neg <= w4_neg;
      m1_den <= w4_den;
      m1_ctx <= w4_ctx;
      m2_kk  <= (94'(m1_hi) << 32) + 94'(m1_lo);
      m2_neg <= m1_neg;
      m2_den <= m1_den;
      m2_ctx <= m1_ctx;
    end
  end

  // M3/M4: times each mass (center gain uses the neighbor mass)
  logic [31:0]     mass_c;
  logic [31:0]     mass_n;
  logic [63:0]     m3_c0;
  logic [63:0]     m3_c1;
  logic [61:0]     m3_c2;
  logic [63:0]     m3_n0;
  logic [63:0]     m3_n1;
  logic [61:0]     m3_n2;
  logic            m3_neg;
  logic [DenW-1:0] m3_den;
  logic [2:0]      m3_flags;
  logic [ProdW-1:0] m4_nc;
  logic [ProdW-1:0] m4_nn;
  logic            m4_neg;
  logic [DenW-1:0] m4_den;
  logic [2:0]      m4_flags;

  assign mass_c = m2_ctx[CtxW-1 -: 32];
  assign mass_n = m2_ctx[33:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_c0    <= 64'(m2_kk[31:0]) * 64'(mass_n);
      m3_c1    <= 64'(m2_kk[63:32]) * 64'(mass_n);
      m3_c2    <= 62'(m2_kk[93:64]) * 62'(mass_n);
      m3_n0    <= 64'(m2_kk[31:0]) * 64'(mass_c);
      m3_n1    <= 64'(m2_kk[63:32]) * 64'(mass_c);
      m3_n2    <= 62'(m2_kk[93:64]) * 62'(mass_c);
      m3_neg   <= m2_neg;
      m3_den   <= m2_den;
      m3_flags <= {m2_neg, m2_ctx[1:0]};
      m4_nc    <= 126'(m3_c0) + (126'(m3_c1) << 32) + (126'(m3_c2) << 64);
      m4_nn    <= 126'(m3_n0) + (126'(m3_n1) << 32) + (126'(m3_n2) << 64);
      m4_neg   <= m3_neg;
      m4_den   <= m3_den;
      m4_flags <= m3_flags;
    end
  end

  // D0: apply the format shift, split into divider head and tail, cap check
  logic [NxW-1:0] nx_c;
  logic [NxW-1:0] nx_n;
  logic [HiW-1:0] hi_c;
  logic [HiW-1:0] hi_n;
  logic [NxW-1:0] np_c;
  logic [NxW-1:0] np_n;
  logic           cap_c;
  logic           cap_n;

  assign nx_c  = NxW'(m4_nc) << PadL;
  assign nx_n  = NxW'(m4_nn) << PadL;
  assign np_c  = nx_c >> PadR;
  assign np_n  = nx_n >> PadR;
  assign hi_c  = np_c[NxW-1:QuoW];
  assign hi_n  = np_n[NxW-1:QuoW];
  assign cap_c = (hi_c >= HiW'(m4_den));
  assign cap_n = (hi_n >= HiW'(m4_den));

  logic [DenW-1:0] d0_rem_c;
  logic [DenW-1:0] d0_rem_n;
  logic [QuoW-1:0] d0_lo_c;
  logic [QuoW-1:0] d0_lo_n;
  logic            d0_cap_c;
  logic            d0_cap_n;
  logic [DenW-1:0] d0_den;
  logic [2:0]      d0_flags;

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_rem_c <= cap_c ? '0 : hi_c[DenW-1:0];
      d0_rem_n <= cap_n ? '0 : hi_n[DenW-1:0];
      d0_lo_c  <= np_c[QuoW-1:0];
      d0_lo_n  <= np_n[QuoW-1:0];
      d0_cap_c <= cap_c;
      d0_cap_n <= cap_n;
      d0_den   <= m4_den;
      d0_flags <= {m4_neg, m4_flags[1:0]};
    end
  end

  // Gain dividers
  logic [QuoW-1:0] q_c;
  logic [QuoW-1:0] q_n;
  logic [3:0]      e_side;
  logic            e_cap_n;

  sphdk_udiv #(
    .DEN_W (DenW),
    .Q_W   (QuoW),
    .STEP  (1),
    .SIDE_W(4)
  ) u_center_div (
    .clk     (clk),
    .en      (adv),
    .rem_in  (d0_rem_c),
    .num_lo  (d0_lo_c),
    .den     (d0_den),
    .side_in ({d0_cap_c, d0_flags}),
    .quo     (q_c),
    .side_out(e_side)
  );

  sphdk_udiv #(
    .DEN_W (DenW),
    .Q_W   (QuoW),
    .STEP  (1),
    .SIDE_W(1)
  ) u_neighbor_div (
    .clk     (clk),
    .en      (adv),
    .rem_in  (d0_rem_n),
    .num_lo  (d0_lo_n),
    .den     (d0_den),
    .side_in (d0_cap_n),
    .quo     (q_n),
    .side_out(e_cap_n)
  );

  // Output: sign, saturation, zero ball
  logic            e_cap_c;
  logic            e_neg;
  logic            e_last;
  logic            e_bz;
  logic [GainW-1:0] gain_c;
  logic [GainW-1:0] gain_n;

  assign e_cap_c = e_side[3];
  assign e_neg   = e_side[2];
  assign e_last  = e_side[1];
  assign e_bz    = e_side[0];

  always_comb begin
    logic [GainW-1:0] mag_c;
    logic [GainW-1:0] mag_n;
    mag_c = e_cap_c ? sphdk_pkg::GAIN_CAP : GainW'(q_c);
    mag_n = e_cap_n ? sphdk_pkg::GAIN_CAP : GainW'(q_n);
    if (e_bz) begin
      gain_c = '0;
      gain_n = '0;
    end else if (e_neg) begin
      gain_c = '0 - mag_c;
      gain_n = '0 - mag_n;
    end else begin
      gain_c = e_cap_c ? sphdk_pkg::GAIN_MAX : mag_c;
      gain_n = e_cap_n ? sphdk_pkg::GAIN_MAX : mag_n;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.center_gain     <= gain_c;
      result.neighbor_gain   <= gain_n;
      result.kernel_negative <= e_neg && !e_bz;
      result.ball_zero       <= e_bz;
      result.last_out        <= e_last;
    end
  end

endmodule

### rtl/sphdk_checker.sv
// Port-level checker for the density pair kernel, bound to the top level.
`include "assert_macros.svh"

module sphdk_checker (
  input logic               clk,
  input logic               rst,
  input logic               pair_ready,
  input logic               result_valid,
  input logic               result_ready,
  input sphdk_pkg::result_t result
);

  // A stalled result keeps its valid and payload
  `SPHDK_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready,
    result_valid && $stable(result), "result changed while stalled")

  // Input is taken exactly when the output side can move
  `SPHDK_ASSERT_NOW(a_ready_rule, clk, rst, 1'b1,
    pair_ready == (!result_valid || result_ready), "pair_ready out of step with output")

  // Zero ball gives zero gains and no negative flag
  `SPHDK_ASSERT_NOW(a_zero_ball, clk, rst, result_valid && result.ball_zero,
    result.center_gain == '0 && result.neighbor_gain == '0 && !result.kernel_negative,
    "zero ball with nonzero output")

  // Negative kernel never yields a positive gain
  `SPHDK_ASSERT_NOW(a_neg_sign, clk, rst, result_valid && result.kernel_negative,
    (result.center_gain[47] || result.center_gain == '0) &&
    (result.neighbor_gain[47] || result.neighbor_gain == '0),
    "positive gain on negative kernel")

  // Non-negative kernel never yields a negative gain
  `SPHDK_ASSERT_NOW(a_pos_sign, clk, rst, result_valid && !result.kernel_negative,
    !result.center_gain[47] && !result.neighbor_gain[47],
    "negative gain on non-negative kernel")

endmodule

bind sph_density_pair_kernel_core sphdk_checker u_sphdk_checker (
  .clk          (clk),
  .rst          (rst),
  .pair_ready   (pair_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

### tb/sv/tb_sph_density_pair_kernel_core.sv
// Testbench for the SPH cubic-spline density pair kernel core.
module tb_sph_density_pair_kernel_core;

  localparam int LEN_FB  = sphdk_pkg::LEN_FRAC_BITS_DEF;
  localparam int MASS_FB = sphdk_pkg::MASS_FRAC_BITS_DEF;
  localparam int ROOT_PRESHIFT = 32 - (LEN_FB % 2);
  localparam int GAIN_SHIFT = LEN_FB + (LEN_FB + ROOT_PRESHIFT) / 2 - MASS_FB - 38;
  localparam int N_RANDOM = 1530;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 500;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    pair_valid = 1'b0;
  logic    pair_ready;
  sphdk_pkg::pair_t   pair = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  sphdk_pkg::result_t result;

  sphdk_pkg::pair_t   pending_pairs[$];
  sphdk_pkg::result_t expected_results[$];
  int      n_accepted = 0;
  int      n_received = 0;
  int      n_mismatch = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  bit      pause_on = 1'b0;
  bit      pause_done = 1'b0;
  int      cycles = 0;

  sph_density_pair_kernel_core DUT (
    .clk(clk), .rst(rst),
    .pair_valid(pair_valid), .pair_ready(pair_ready), .pair(pair),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // integer square root, floor
  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    r = '0;
    bitv = 64'h1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // gain magnitude, capped at 2^47
  function automatic logic [47:0] gain_magnitude(input logic [62:0] kw, input logic [31:0] m,
                                                 input logic [63:0] den);
    logic [255:0] num;
    logic [255:0] lim;
    num = 256'(kw) * 256'(m) * 256'(sphdk_pkg::NORM_CONST);
    if (GAIN_SHIFT >= 0) num = num << GAIN_SHIFT;
    else num = num >> (-GAIN_SHIFT);
    lim = 256'(den) << 47;
    if (num >= lim) return sphdk_pkg::GAIN_CAP;
    return 48'(num / 256'(den));
  endfunction

  function automatic logic [47:0] apply_sign(input bit neg, input logic [47:0] mag);
    if (neg) return 48'(0) - mag;
    return (mag > sphdk_pkg::GAIN_MAX) ? sphdk_pkg::GAIN_MAX : mag;
  endfunction

  // expected density increments for one pair
  function automatic sphdk_pkg::result_t density_gains(input sphdk_pkg::pair_t p);
    sphdk_pkg::result_t r;
    logic [63:0] d, b, ratio, s, rem, qv, rs, a, sb, den;
    logic [127:0] wide;
    logic [62:0] kw;
    bit neg;
    r = '0;
    r.last_out = p.last_pair;
    neg = 1'b0;
    d = 64'(p.dist_sq);
    b = 64'(p.ball_sq);
    if (b == 0) begin
      r.ball_zero = 1'b1;
      return r;
    end
    ratio = (d << 32) / b;
    s = root_floor(ratio);
    rem = ratio - s * s;
    qv = 2 * s + (((4 * rem) >= (4 * s + 1)) ? 64'd1 : 64'd0);
    if (ratio < (64'h1 << 30)) begin
      rs = (64'h1 << 17) - qv;
      wide = (128'd3 * 128'(rs) * (128'd4 * 128'(ratio))) >> 18;
      kw = 63'((128'h1 << 32) - wide);
    end else if (qv <= (64'h1 << 17)) begin
      rs = (64'h1 << 17) - qv;
      kw = 63'((128'(rs) * 128'(rs) * 128'(rs)) >> 18);
    end else begin
      a = qv - (64'h1 << 17);
      neg = 1'b1;
      wide = (128'(a) * 128'(a) * 128'(a)) >> 18;
      kw = (wide > 128'(sphdk_pkg::W_CAP)) ? sphdk_pkg::W_CAP : 63'(wide);
    end
    sb = root_floor(b << ROOT_PRESHIFT);
    den = b * sb;
    r.center_gain = apply_sign(neg, gain_magnitude(kw, p.neighbor_mass, den));
    r.neighbor_gain = apply_sign(neg, gain_magnitude(kw, p.center_mass, den));
    r.kernel_negative = neg;
    return r;
  endfunction

  // 32-bit value with a random magnitude
  function automatic logic [31:0] rand_scaled();
    return $urandom >> $urandom_range(31, 0);
  endfunction

  function automatic sphdk_pkg::pair_t make_pair(input logic [31:0] d, input logic [31:0] b,
                                                 input logic [31:0] mc, input logic [31:0] mn,
                                                 input logic lp);
    sphdk_pkg::pair_t p;
    p.dist_sq = d;
    p.ball_sq = b;
    p.center_mass = mc;
    p.neighbor_mass = mn;
    p.last_pair = lp;
    return p;
  endfunction

  function automatic sphdk_pkg::pair_t random_pair();
    logic [31:0] b;
    logic [31:0] d;
    int kind;
    kind = $urandom_range(99, 0);
    b = (kind < 50) ? rand_scaled() : $urandom;
    if (b == 0) b = 32'd1;
    if (kind < 70) begin
      // inside the ball
      d = 32'((64'(b) * 64'($urandom_range(65536, 0))) >> 16);
    end else if (kind < 85) begin
      d = rand_scaled();
    end else if (kind < 92) begin
      b = '0;
      d = $urandom;
    end else begin
      d = $urandom;
      b = $urandom;
    end
    return make_pair(d, b, ($urandom_range(1, 0) != 0) ? $urandom : rand_scaled(),
                     ($urandom_range(1, 0) != 0) ? $urandom : rand_scaled(),
                     1'($urandom_range(1, 0)));
  endfunction

  // idle only outside the quiet stretch
  function automatic bit want_idle(input int count);
    if (count >= 300 && count < 600) return 1'b0;
    return $urandom_range(99, 0) < 12;
  endfunction

  // sender: pops pending pairs, records expectations on each transfer
  always @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else begin
      if (pair_valid && pair_ready) begin
        expected_results.push_back(density_gains(pair));
        n_accepted++;
        if (n_accepted == 900 && !pause_done) pause_on = 1'b1;
      end
      if (pause_on && expected_results.size() == 0) begin
        pause_on = 1'b0;
        pause_done = 1'b1;
      end
      if (!pair_valid || pair_ready) begin
        if (pending_pairs.size() == 0 || pause_on || want_idle(n_accepted)) begin
          pair_valid <= 1'b0;
        end else begin
          pair <= pending_pairs.pop_front();
          pair_valid <= 1'b1;
        end
      end
    end
  end

  // receiver: checks each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result %h", result);
        end else begin
          sphdk_pkg::result_t e;
          e = expected_results.pop_front();
          if (e.center_gain !== result.center_gain ||
              e.neighbor_gain !== result.neighbor_gain ||
              e.kernel_negative !== result.kernel_negative ||
              e.ball_zero !== result.ball_zero ||
              e.last_out !== result.last_out) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("mismatch at result %0d: cg %h/%h ng %h/%h neg %b/%b bz %b/%b last %b/%b",
                       n_received, e.center_gain, result.center_gain, e.neighbor_gain,
                       result.neighbor_gain, e.kernel_negative, result.kernel_negative,
                       e.ball_zero, result.ball_zero, e.last_out, result.last_out);
          end
        end
        n_received++;
        if (n_received == 200 && !hold_done) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= !want_idle(n_received);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sph_density_pair_kernel_core test failed");
      $finish;
    end
  end

  initial begin
    // directed corners
    pending_pairs.push_back(make_pair(32'd0, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1));
    pending_pairs.push_back(make_pair(32'hFFFFFFFF, 32'd0, 32'd1, 32'd1, 1'b0));
    pending_pairs.push_back(make_pair(32'd0, 32'h01000000, 32'h00010000, 32'h00010000, 1'b0));
    pending_pairs.push_back(make_pair(32'd0, 32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1));
    pending_pairs.push_back(make_pair(32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0));
    pending_pairs.push_back(make_pair(32'h00400000, 32'h01000000, 32'h00010000, 32'h00020000,
                                      1'b0));
    pending_pairs.push_back(make_pair(32'h003FFFFF, 32'h01000000, 32'h00010000, 32'h00010000,
                                      1'b0));
    pending_pairs.push_back(make_pair(32'h00800000, 32'h01000000, 32'h00030000, 32'h00010000,
                                      1'b0));
    pending_pairs.push_back(make_pair(32'h01000000, 32'h01000000, 32'h00010000, 32'h00010000,
                                      1'b1));
    pending_pairs.push_back(make_pair(32'h01000001, 32'h01000000, 32'h00010000, 32'h00010000,
                                      1'b0));
    pending_pairs.push_back(make_pair(32'h04000000, 32'h01000000, 32'h00010000, 32'h00010000,
                                      1'b0));
    pending_pairs.push_back(make_pair(32'hFFFFFFFF, 32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1));
    pending_pairs.push_back(make_pair(32'hFFFFFFFF, 32'd1, 32'd0, 32'd1, 1'b0));
    pending_pairs.push_back(make_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd5, 32'd7, 1'b0));
    pending_pairs.push_back(make_pair(32'd1, 32'd1, 32'hFFFFFFFF, 32'd0, 1'b0));
    pending_pairs.push_back(make_pair(32'd0, 32'd4, 32'd0, 32'd0, 1'b1));
    pending_pairs.push_back(make_pair(32'd1, 32'd16, 32'hFFFFFFFF, 32'h80000000, 1'b0));
    pending_pairs.push_back(make_pair(32'h7FFFFFFF, 32'h80000000, 32'h12345678, 32'h9ABCDEF0,
                                      1'b0));
    pending_pairs.push_back(make_pair(32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
                                      1'b1));
    pending_pairs.push_back(make_pair(32'hAAAAAAAA, 32'h55555555, 32'h55555555, 32'hAAAAAAAA,
                                      1'b0));
    for (int i = 0; i < N_RANDOM; i++) pending_pairs.push_back(random_pair());

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || pair_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_mismatch == 0) begin
      $display("sph_density_pair_kernel_core test passed");
    end else begin
      $display("sph_density_pair_kernel_core test failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/sphdk_pkg.sv
rtl/sphdk_udiv.sv
rtl/sphdk_isqrt.sv
rtl/sph_density_pair_kernel_core.sv
rtl/sphdk_checker.sv
tb/sv/tb_sph_density_pair_kernel_core.sv
